// ----- design/hsa_pkg.sv -----
// Shared constants, types and the transaction record for the heightmap surface area block.
// No dependencies; every other file in the design imports this package.
package hsa_pkg;

  localparam int MAX_COLS   = 4096;
  localparam int MAX_ROWS   = 8192;
  localparam int COL_W      = $clog2(MAX_COLS);
  localparam int ROW_W      = $clog2(MAX_ROWS);
  localparam int H_W        = 16;
  localparam int RAD_W      = 2 * H_W + 16;
  localparam int ROOT_W     = RAD_W / 2;
  localparam int REM_W      = ROOT_W + 2;
  localparam int STEP_W     = $clog2(ROOT_W);
  localparam int PROD_W     = 2 * ROOT_W;
  localparam int SUM_W      = 64;
  localparam int Q_DEPTH    = 4;
  localparam int Q_PTR_W    = $clog2(Q_DEPTH);
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int COLS_REG_W = 13;
  localparam int ROWS_REG_W = 14;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_COLS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROWS = 2'd1;

  // One classified sample handed from the front end to the arithmetic back end.
  typedef struct packed {
    logic [H_W-1:0] h;
    logic [H_W-1:0] above;
    logic [H_W-1:0] upright;
    logic           contrib;
    logic           last;
  } entry_t;

endpackage

// ----- design/hsa_front.sv -----
// Front end: tracks raster position, owns the line buffer and classifies each sample.
// Depends on hsa_pkg.
module hsa_front import hsa_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [H_W-1:0]   sample_height,
  input  logic [COL_W-1:0] cols_last,
  input  logic [ROW_W-1:0] rows_last,
  input  logic [Q_PTR_W:0] q_count,
  output logic             q_push,
  output entry_t           q_entry
);

  logic [H_W-1:0]   line_mem [MAX_COLS];
  logic [COL_W-1:0] col;
  logic [ROW_W-1:0] row;
  logic [H_W-1:0]   rd_above;
  logic [H_W-1:0]   rd_upright;
  logic             s1_valid;
  logic [H_W-1:0]   s1_h;
  logic             s1_contrib;
  logic             s1_last;
  logic [COL_W-1:0] c;
  logic             last_col;
  logic             last_row;
  logic             accept;

  // Leave room in the queue for the sample still in the read stage.
  assign in_ready = ({1'b0, q_count} + {{(Q_PTR_W+1){1'b0}}, s1_valid}) < (Q_PTR_W+2)'(Q_DEPTH);
  assign accept   = in_valid && in_ready;

  // A column past a shrunken row width counts as the last column.
  assign c        = (col > cols_last) ? cols_last : col;
  assign last_col = (c == cols_last);
  assign last_row = (row >= rows_last);

  // Line buffer: read-first, so the reads see the previous row.
  always_ff @(posedge clk) begin
    if (accept) begin
      line_mem[c] <= sample_height;
      rd_above    <= line_mem[c];
      rd_upright  <= line_mem[c + COL_W'(1)];
      s1_h        <= sample_height;
      s1_contrib  <= (row != '0) && !last_col;
      s1_last     <= last_col && last_row;
    end
  end

  // Raster position and read stage valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      col      <= '0;
      row      <= '0;
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
      if (accept) begin
        if (last_col && last_row) begin
          col <= '0;
          row <= '0;
        end else if (last_col) begin
          col <= '0;
          row <= row + ROW_W'(1);
        end else begin
          col <= c + COL_W'(1);
        end
      end
    end
  end

  // Classified sample goes to the queue once the buffer data is back.
  assign q_push          = s1_valid;
  assign q_entry.h       = s1_h;
  assign q_entry.above   = rd_above;
  assign q_entry.upright = rd_upright;
  assign q_entry.contrib = s1_contrib;
  assign q_entry.last    = s1_last;

endmodule

// ----- design/hsa_queue.sv -----
// Short FIFO of classified samples between the front end and the back end.
// Depends on hsa_pkg.
module hsa_queue import hsa_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  entry_t           push_entry,
  input  logic             pop,
  output entry_t           head,
  output logic             not_empty,
  output logic [Q_PTR_W:0] count
);

  entry_t             slots [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr;
  logic [Q_PTR_W-1:0] rd_ptr;

  assign head      = slots[rd_ptr];
  assign not_empty = (count != '0);

  // Storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + Q_PTR_W'(1);
      if (pop)  rd_ptr <= rd_ptr + Q_PTR_W'(1);
      count <= count + (Q_PTR_W+1)'(push) - (Q_PTR_W+1)'(pop);
    end
  end

endmodule

// ----- design/hsa_back.sv -----
// Back end: two bit-serial square roots, their product and the saturating accumulator.
// Depends on hsa_pkg; holds the output register.
module hsa_back import hsa_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_not_empty,
  input  entry_t           q_head,
  output logic             q_pop,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [SUM_W-1:0] area_total,
  output logic             area_saturated
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SQR  = 3'd1;
  localparam logic [2:0] ST_ROOT = 3'd2;
  localparam logic [2:0] ST_MUL  = 3'd3;
  localparam logic [2:0] ST_ACC  = 3'd4;
  localparam logic [2:0] ST_EMIT = 3'd5;

  typedef struct packed {
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
  } sq_t;

  logic [2:0]        state;
  entry_t            cur;
  logic [RAD_W-1:0]  rad1, rad2;
  sq_t               sq1, sq2;
  sq_t               sq1_next, sq2_next;
  logic [STEP_W-1:0] step;
  logic [PROD_W-1:0] prod;
  logic [SUM_W-1:0]  acc;
  logic              sat;
  logic [H_W-1:0]    mag1, mag2;
  logic [SUM_W:0]    sum_ext;
  logic              emit_fire;

  // One digit of the restoring square root: bring down two bits, try to subtract.
  function automatic sq_t sq_step(input sq_t s, input logic [1:0] bits);
    logic [REM_W:0] rem_sh;
    logic [REM_W:0] trial;
    sq_t            r;
    rem_sh = {s.rem[REM_W-2:0], bits};
    trial  = {1'b0, s.root, 2'b01};
    if (rem_sh >= trial) begin
      r.rem  = REM_W'(rem_sh - trial);
      r.root = {s.root[ROOT_W-2:0], 1'b1};
    end else begin
      r.rem  = REM_W'(rem_sh);
      r.root = {s.root[ROOT_W-2:0], 1'b0};
    end
    return r;
  endfunction

  assign mag1     = (cur.h >= cur.above) ? cur.h - cur.above : cur.above - cur.h;
  assign mag2     = (cur.upright >= cur.above) ? cur.upright - cur.above
                                               : cur.above - cur.upright;
  assign sq1_next = sq_step(sq1, rad1[RAD_W-1 -: 2]);
  assign sq2_next = sq_step(sq2, rad2[RAD_W-1 -: 2]);
  assign sum_ext  = {1'b0, acc} + {{(SUM_W+1-PROD_W){1'b0}}, prod};

  assign q_pop     = (state == ST_IDLE) && q_not_empty;
  assign emit_fire = (state == ST_EMIT) && (!out_valid || out_ready);

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_head;
    end
    case (state)
      ST_SQR: begin
        rad1 <= {(2*H_W)'(mag1) * (2*H_W)'(mag1) + (2*H_W)'(1), 16'd0};
        rad2 <= {(2*H_W)'(mag2) * (2*H_W)'(mag2) + (2*H_W)'(1), 16'd0};
        sq1  <= '0;
        sq2  <= '0;
      end
      ST_ROOT: begin
        sq1  <= sq1_next;
        sq2  <= sq2_next;
        rad1 <= rad1 << 2;
        rad2 <= rad2 << 2;
      end
      ST_MUL: begin
        prod <= PROD_W'(sq1.root) * PROD_W'(sq2.root);
      end
      default: begin
      end
    endcase
    if (q_pop && !q_head.contrib) begin
      prod <= '0;
    end
    if (emit_fire) begin
      area_total     <= acc;
      area_saturated <= sat;
    end
  end

  // Sequencer, accumulator and output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      step      <= '0;
      acc       <= '0;
      sat       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // A new total is loaded when the output register is free or being taken.
      if (emit_fire) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (q_pop) state <= q_head.contrib ? ST_SQR : ST_ACC;
        end
        ST_SQR: begin
          step  <= '0;
          state <= ST_ROOT;
        end
        ST_ROOT: begin
          step <= step + STEP_W'(1);
          if (step == STEP_W'(ROOT_W - 1)) state <= ST_MUL;
        end
        ST_MUL: begin
          state <= ST_ACC;
        end
        ST_ACC: begin
          if (sum_ext[SUM_W]) begin
            acc <= '1;
            sat <= 1'b1;
          end else begin
            acc <= sum_ext[SUM_W-1:0];
          end
          state <= cur.last ? ST_EMIT : ST_IDLE;
        end
        ST_EMIT: begin
          if (emit_fire) begin
            acc   <= '0;
            sat   <= 1'b0;
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // A saturated frame total is pinned at full scale.
  a_sat_full: assert property (@(posedge clk) disable iff (rst) sat |-> (acc == '1))
    else $error("saturation flag set with accumulator below full scale");

  // Emitting a total clears the frame accumulator.
  a_emit_clears: assert property (@(posedge clk) disable iff (rst)
    emit_fire |=> (acc == '0) && !sat && out_valid)
    else $error("accumulator not cleared after emitting a total");

  // The root sequencer never runs past its last digit.
  a_step_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ROOT) |-> (step <= STEP_W'(ROOT_W - 1)))
    else $error("square root step counter out of range");

endmodule

// ----- design/heightmap_surface_area.sv -----
// Heightmap surface area block: the front end takes samples into a line buffer and a
// four-entry queue; the back end takes one sample at a time from the queue and steps a
// contributing sample through pop, square, 24 root digits, multiply and accumulate, and
// any other sample through pop and accumulate, so input stalls once the queue has filled.
// A frame total is loaded into the output register once the frame's last sample has been
// accumulated, after every sample queued ahead of it. Sync reset: sizes 4096 x 4096.
module heightmap_surface_area import hsa_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [H_W-1:0]        sample_height,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [SUM_W-1:0]      area_total,
  output logic                  area_saturated,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [COLS_REG_W-1:0] cols_in_use;
  logic [ROWS_REG_W-1:0] rows_in_use;
  logic [COL_W-1:0]      cols_last;
  logic [ROW_W-1:0]      rows_last;
  logic [Q_PTR_W:0]      q_count;
  logic                  q_push;
  logic                  q_pop;
  logic                  q_not_empty;
  entry_t                q_entry;
  entry_t                q_head;

  assign cfg_ready = 1'b1;

  // Configuration registers; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      cols_in_use <= COLS_REG_W'(4096);
      rows_in_use <= ROWS_REG_W'(4096);
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_COLS: cols_in_use <= cfg_data[COLS_REG_W-1:0];
        REG_ROWS: rows_in_use <= cfg_data[ROWS_REG_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Clamp the sizes and form the last column and last row indexes.
  always_comb begin
    if (cols_in_use < COLS_REG_W'(2))             cols_last = COL_W'(1);
    else if (cols_in_use > COLS_REG_W'(MAX_COLS)) cols_last = COL_W'(MAX_COLS - 1);
    else                                          cols_last = COL_W'(cols_in_use - 1'b1);
    if (rows_in_use < ROWS_REG_W'(2))             rows_last = ROW_W'(1);
    else if (rows_in_use > ROWS_REG_W'(MAX_ROWS)) rows_last = ROW_W'(MAX_ROWS - 1);
    else                                          rows_last = ROW_W'(rows_in_use - 1'b1);
  end

  hsa_front u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .sample_height (sample_height),
    .cols_last     (cols_last),
    .rows_last     (rows_last),
    .q_count       (q_count),
    .q_push        (q_push),
    .q_entry       (q_entry)
  );

  hsa_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (q_entry),
    .pop        (q_pop),
    .head       (q_head),
    .not_empty  (q_not_empty),
    .count      (q_count)
  );

  hsa_back u_back (
    .clk            (clk),
    .rst            (rst),
    .q_not_empty    (q_not_empty),
    .q_head         (q_head),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .area_total     (area_total),
    .area_saturated (area_saturated)
  );

endmodule
